FILE: sv/max_type_standardized_statistic_macros.svh
// Assertion macros for the max-type standardised statistic block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MAX_TYPE_STANDARDIZED_STATISTIC_MACROS_SVH
`define MAX_TYPE_STANDARDIZED_STATISTIC_MACROS_SVH

// Property holds on every clock edge out of reset.
`define MTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next edge.
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mts_pkg.sv
// Shared types and constants for the max-type standardised statistic block.
// No dependencies.
package mts_pkg;

  localparam int FracBits = 16;
  localparam int RootInW  = 32 + FracBits;     // variance << F
  localparam int RootW    = RootInW / 2;       // root width
  localparam int RootIter = RootW;
  localparam int DivNumW  = 33 + FracBits;     // |d| << F, |d| below 2^32
  localparam int DivIter  = DivNumW;

  localparam logic [1:0] ModeTwoSided = 2'd0;
  localparam logic [1:0] ModeLess     = 2'd1;
  localparam logic [1:0] ModeGreater  = 2'd2;

  localparam logic CfgIdxMode = 1'b0;
  localparam logic CfgIdxTol  = 1'b1;

  // Classified element passed from front to back.
  typedef struct packed {
    logic [32:0]    mag;      // |d|
    logic           neg;      // d < 0
    logic [31:0]    variance;
    logic           zero;     // variance within tolerance
    logic           last;
    logic [1:0]     mode;
  } elem_t;

  localparam int QueueDepth = 2;

endpackage

FILE: sv/mts_if.sv
// Valid/ready stream interfaces for the max-type standardised statistic block.
// Depends on nothing; payload fields are kept at their natural widths.
interface mts_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] linear_stat;
  logic signed [31:0] expectation;
  logic [31:0] variance;
  logic        last_element;
  modport source (output valid, linear_stat, expectation, variance, last_element,
                  input ready);
  modport sink (input valid, linear_stat, expectation, variance, last_element,
                output ready);
endinterface

interface mts_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] statistic;
  logic        saturated;
  modport source (output valid, statistic, saturated, input ready);
  modport sink (input valid, statistic, saturated, output ready);
endinterface

interface mts_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/mts_front.sv
// Front end: takes input beats, forms |d| and the tolerance test, queues them.
// Depends on mts_pkg and mts_if.
module mts_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mts_in_if.sink        in_if,
  input  logic [1:0]    mode_i,
  input  logic [31:0]   tol_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output mts_pkg::elem_t q_data_o
);
  import mts_pkg::*;

  elem_t       mem_q [QueueDepth];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic signed [32:0] diff;
  elem_t       e;
  logic        push;

  assign diff = 33'(in_if.linear_stat) - 33'(in_if.expectation);
  always_comb begin
    e.neg      = diff[32];
    e.mag      = diff[32] ? 33'(-diff) : 33'(diff);
    e.variance = in_if.variance;
    e.zero     = in_if.variance <= tol_i;
    e.last     = in_if.last_element;
    e.mode     = mode_i;
  end

  assign in_if.ready = cnt_q != 2'(QueueDepth);
  assign push        = in_if.valid && in_if.ready;
  assign q_valid_o   = cnt_q != 2'd0;
  assign q_data_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

FILE: sv/mts_back.sv
// Back end: iterative square root and divide, clipping, running extreme.
// Depends on mts_pkg, mts_if and the assertion macros header.
`include "max_type_standardized_statistic_macros.svh"
module mts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  mts_pkg::elem_t q_data_i,
  mts_out_if.source      out_if
);
  import mts_pkg::*;

  typedef enum logic [2:0] {StIdle, StRoot, StDiv, StUpd, StOut} state_e;
  state_e state_q;

  elem_t              el_q;
  logic [RootInW-1:0] rx_q;
  logic [RootW-1:0]   rres_q;
  logic [RootW+1:0]   rrem_q;
  logic [5:0]         cnt_q;
  logic [DivNumW-1:0] num_q;
  logic [RootW:0]     drem_q;
  logic signed [31:0] ext_q;
  logic               sat_q;

  // one restoring root step: two bits in
  logic [RootW+1:0] r_trial, r_rem;
  logic [RootW+1:0] r_sub;
  always_comb begin
    r_rem   = {rrem_q[RootW-1:0], rx_q[RootInW-1 -: 2]};
    r_sub   = {rres_q, 2'b01};
    r_trial = r_rem - r_sub;
  end

  // one restoring divide step
  logic [RootW+1:0] d_sh, d_try;
  always_comb begin
    d_sh  = {drem_q, num_q[DivNumW-1]};
    d_try = d_sh - {2'b00, rres_q};
  end

  // clip and extreme update
  logic [DivNumW-1:0] q_abs;
  logic signed [31:0] z;
  logic               clip;
  assign q_abs = num_q;
  always_comb begin
    z = '0; clip = 1'b0;
    if (!el_q.zero && rres_q != '0) begin
      if (el_q.mode == ModeTwoSided || !el_q.neg) begin
        if (q_abs > DivNumW'(32'h7fffffff)) begin z = 32'h7fffffff; clip = 1'b1; end
        else z = q_abs[31:0];
      end else begin
        if (q_abs > DivNumW'(33'h80000000)) begin z = 32'h80000000; clip = 1'b1; end
        else z = 32'(-q_abs[32:0]);
      end
    end
  end
  logic signed [31:0] ext_n;
  always_comb begin
    ext_n = ext_q;
    if (el_q.mode == ModeLess) begin
      if (z < ext_q) ext_n = z;
    end else if (z > ext_q) ext_n = z;
  end

  assign q_pop_o = state_q == StIdle && q_valid_i;
  assign out_if.valid = state_q == StOut;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ext_q <= '0; sat_q <= 1'b0; cnt_q <= '0;
    end else begin
      case (state_q)
        StIdle: if (q_valid_i) begin
          el_q   <= q_data_i;
          rx_q   <= {q_data_i.variance, FracBits'(0)};
          rres_q <= '0; rrem_q <= '0; cnt_q <= '0;
          state_q <= q_data_i.zero ? StUpd : StRoot;
        end
        StRoot: begin
          rx_q <= rx_q << 2;
          if (!r_trial[RootW+1]) begin
            rrem_q <= r_trial; rres_q <= {rres_q[RootW-2:0], 1'b1};
          end else begin
            rrem_q <= r_rem;   rres_q <= {rres_q[RootW-2:0], 1'b0};
          end
          if (cnt_q == 6'(RootIter - 1)) begin
            cnt_q <= '0; drem_q <= '0;
            num_q <= {el_q.mag, FracBits'(0)};
            state_q <= StDiv;
          end else cnt_q <= cnt_q + 6'd1;
        end
        StDiv: begin
          if (rres_q == '0) state_q <= StUpd;
          else begin
            if (!d_try[RootW+1]) begin
              drem_q <= d_try[RootW:0]; num_q <= {num_q[DivNumW-2:0], 1'b1};
            end else begin
              drem_q <= d_sh[RootW:0];  num_q <= {num_q[DivNumW-2:0], 1'b0};
            end
            if (cnt_q == 6'(DivIter - 1)) state_q <= StUpd;
            else cnt_q <= cnt_q + 6'd1;
          end
        end
        StUpd: begin
          if (el_q.last) begin
            out_if.statistic <= ext_n; out_if.saturated <= sat_q | clip;
            ext_q <= '0; sat_q <= 1'b0; state_q <= StOut;
          end else begin
            ext_q <= ext_n; sat_q <= sat_q | clip; state_q <= StIdle;
          end
        end
        StOut: if (out_if.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  `MTS_ASSERT(a_pop_idle, clk_i, rst_ni, !q_pop_o || state_q == StIdle, "pop outside idle")
  `MTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid, "result dropped")
  `MTS_ASSERT_NEXT(a_clear, clk_i, rst_ni, out_if.valid, ext_q == '0 || state_q != StOut, "extreme not cleared")
endmodule

FILE: sv/max_type_standardized_statistic.sv
// Max-type standardised statistic over a stream of elements.
// Beats arrive on in_if: statistic, expectation, variance and last mark.
// The front end forms |d| and the tolerance test and queues two elements.
// The back end runs a restoring square root and a restoring divide, one bit
// per cycle, then updates the running extreme. An element holds the back
// end through the idle, root, divide and update states (idle and update
// only when within tolerance), plus the result state until taken when it
// closes a set. It takes no new element before then, so the back end sets
// the rate.
// A last-element beat yields one result beat on out_if, held until ready;
// while it is stalled the front queue keeps taking beats until it is full.
// The user must write cfg_if register 0 (mode) or 1 (tolerance) only while
// idle; the block does not enforce it. Reset clears the extreme, flag, queue
// and registers. Depends on mts_pkg, mts_if, mts_front and mts_back.
module max_type_standardized_statistic (
  input  logic   clk_i,
  input  logic   rst_ni,
  mts_cfg_if.sink cfg_if,
  mts_in_if.sink  in_if,
  mts_out_if.source out_if
);
  import mts_pkg::*;

  logic [1:0]  mode_q;
  logic [31:0] tol_q;
  logic        qv, pop;
  elem_t       qd;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeTwoSided; tol_q <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CfgIdxMode: mode_q <= cfg_if.data[1:0];
        CfgIdxTol:  tol_q  <= cfg_if.data;
        default: ;
      endcase
    end
  end

  mts_front u_front (.clk_i, .rst_ni, .in_if, .mode_i(mode_q), .tol_i(tol_q),
                     .q_valid_o(qv), .q_pop_i(pop), .q_data_o(qd));
  mts_back u_back (.clk_i, .rst_ni, .q_valid_i(qv), .q_pop_o(pop), .q_data_i(qd),
                   .out_if);
endmodule

FILE: test/tb.sv
// Self-checking bench for max_type_standardized_statistic: directed table, then random sets.
// Depends on mts_pkg, mts_if and the block itself; predicts each set's extreme in SV.
module tb;
  import mts_pkg::*;

  logic clk_i;
  logic rst_ni;

  mts_cfg_if cfg_if ();
  mts_in_if  in_if ();
  mts_out_if out_if ();

  max_type_standardized_statistic DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_if(cfg_if),
    .in_if (in_if),
    .out_if(out_if)
  );

  typedef struct packed {
    logic signed [31:0] statistic;
    logic               saturated;
  } set_result_t;

  typedef struct {
    logic signed [31:0] lin;
    logic signed [31:0] expv;
    logic [31:0]        var_q;
    logic               last;
    logic               has_exp;
    set_result_t        exp_res;
  } row_t;

  // predictor state
  logic [1:0]         mode_q;
  logic [31:0]        tol_q;
  logic signed [63:0] extreme_q;
  logic               sat_q;

  set_result_t expected_sets[$];
  set_result_t typed_sets[$];
  logic        typed_valid[$];
  int          mismatches;
  bit          failed;
  bit          stim_done;
  bit          hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    begin
      r = 0;
      v = x;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    end
  endfunction

  // Updates the running extreme for one element; returns 1 when a set closes.
  function automatic bit fold_element(input logic signed [31:0] lin,
                                      input logic signed [31:0] expv,
                                      input logic [31:0] var_q, input logic last,
                                      output set_result_t res);
    logic signed [63:0] d;
    logic [63:0]        mag;
    logic [63:0]        root;
    logic [63:0]        q;
    logic signed [63:0] z;
    begin
      d = 64'(lin) - 64'(expv);
      z = 0;
      res = '0;
      if (var_q > tol_q) begin
        root = floor_root({32'd0, var_q} << FracBits);
        mag  = d < 0 ? 64'(-d) : 64'(d);
        q    = root != 0 ? (mag << FracBits) / root : 64'd0;
        if (mode_q != ModeTwoSided && d < 0) begin
          if (q > 64'd2147483648) begin
            q = 64'd2147483648;
            sat_q = 1'b1;
          end
          z = -$signed(q);
        end else begin
          if (q > 64'd2147483647) begin
            q = 64'd2147483647;
            sat_q = 1'b1;
          end
          z = $signed(q);
        end
      end
      if (mode_q == ModeLess) begin
        if (z < extreme_q) extreme_q = z;
      end else if (z > extreme_q) begin
        extreme_q = z;
      end
      if (!last) return 0;
      res.statistic = extreme_q[31:0];
      res.saturated = sat_q;
      extreme_q = 0;
      sat_q = 1'b0;
      return 1;
    end
  endfunction

  task automatic send_element(input row_t r);
    set_result_t res;
    int gap;
    begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_if.valid        <= 1'b1;
      in_if.linear_stat  <= r.lin;
      in_if.expectation  <= r.expv;
      in_if.variance     <= r.var_q;
      in_if.last_element <= r.last;
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);
      if (fold_element(r.lin, r.expv, r.var_q, r.last, res)) begin
        expected_sets.push_back(res);
        typed_valid.push_back(r.has_exp);
        typed_sets.push_back(r.exp_res);
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    begin
      in_if.valid <= 1'b0;
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= val;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      cfg_if.valid <= 1'b0;
      if (idx == CfgIdxMode) mode_q = val[1:0];
      else tol_q = val;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_sets();
    int guard;
    begin
      in_if.valid <= 1'b0;
      guard = 0;
      while (expected_sets.size() != 0 && guard < 200_000) begin
        @(posedge clk_i);
        guard++;
      end
      // non-last elements may still be in the queue and the back end
      repeat (400) @(posedge clk_i);
    end
  endtask

  function automatic row_t mk(input logic [31:0] lin, input logic [31:0] expv,
                              input logic [31:0] var_q, input logic last,
                              input logic has_exp, input logic [31:0] stat,
                              input logic sat);
    row_t r;
    begin
      r.lin = lin;
      r.expv = expv;
      r.var_q = var_q;
      r.last = last;
      r.has_exp = has_exp;
      r.exp_res.statistic = stat;
      r.exp_res.saturated = sat;
      return r;
    end
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_var();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return 32'hffff_ffff;
      2: return $urandom_range(1, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  // directed rows, default mode two-sided, zero tolerance
  row_t dir_rows[$];

  initial begin
    row_t r;
    int   n_items;
    int   set_len;
    int   phase;
    rst_ni        = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CfgIdxMode;
    cfg_if.data   = '0;
    in_if.valid   = 1'b0;
    in_if.linear_stat  = '0;
    in_if.expectation  = '0;
    in_if.variance     = '0;
    in_if.last_element = 1'b0;
    mode_q = ModeTwoSided;
    tol_q  = '0;
    extreme_q = 0;
    sat_q  = 1'b0;
    stim_done = 1'b0;
    hold_off_req = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero variance, then unit variance, then clipping both ways
    dir_rows.push_back(mk(32'h0001_0000, 0, 0, 1, 1, 32'd0, 0));
    dir_rows.push_back(mk(32'h0003_0000, 0, 32'h0001_0000, 1, 1, 32'h0003_0000, 0));
    dir_rows.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'd1, 1, 1, 32'h7fff_ffff, 1));
    dir_rows.push_back(mk(32'h8000_0000, 32'h7fff_ffff, 32'd1, 1, 1, 32'h7fff_ffff, 1));
    dir_rows.push_back(mk(0, 0, 32'hffff_ffff, 1, 1, 32'd0, 0));
    dir_rows.push_back(mk(32'hfffe_0000, 0, 32'h0001_0000, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1, 1, 32'h0002_0000, 0));
    dir_rows.push_back(mk(32'hffff_ffff, 32'h0000_0001, 32'h0000_0004, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h0000_0002, 1, 0, 0, 0));
    foreach (dir_rows[i]) send_element(dir_rows[i]);
    drain_sets();

    // less mode: minimum and the exact -2^31 bound
    write_reg(CfgIdxMode, {30'd0, ModeLess});
    send_element(mk(32'hfffe_0000, 0, 32'h0001_0000, 0, 0, 0, 0));
    send_element(mk(32'h0005_0000, 0, 32'h0001_0000, 1, 1, 32'hfffe_0000, 0));
    send_element(mk(32'h8000_0000, 0, 32'h0001_0000, 1, 1, 32'h8000_0000, 0));
    send_element(mk(32'h8000_0000, 32'h7fff_ffff, 32'd1, 1, 1, 32'h8000_0000, 1));
    drain_sets();
    // unused mode acts as greater; tolerance at the top masks every element
    write_reg(CfgIdxMode, 32'd3);
    write_reg(CfgIdxTol, 32'hffff_ffff);
    send_element(mk(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1, 1, 32'd0, 0));
    drain_sets();
    write_reg(CfgIdxTol, 32'h0001_0000);
    send_element(mk(32'h0002_0000, 0, 32'h0001_0000, 0, 0, 0, 0));
    send_element(mk(32'hfffd_0000, 0, 32'h0001_0001, 1, 0, 0, 0));
    drain_sets();

    // random phases over several settings
    n_items = 0;
    phase = 0;
    while (n_items < 1650) begin
      if (phase % 2 == 0) begin
        write_reg(CfgIdxMode, $urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0: write_reg(CfgIdxTol, 0);
          1: write_reg(CfgIdxTol, 32'hffff_ffff);
          default: write_reg(CfgIdxTol, $urandom_range(0, 32'h0002_0000));
        endcase
      end
      if (phase == 3) hold_off_req = 1'b1;
      for (int k = 0; k < 100 && n_items < 1650; k++) begin
        set_len = $urandom_range(1, 6);
        for (int e = 0; e < set_len; e++) begin
          r = mk(rand_word(), rand_word(), rand_var(), e == set_len - 1, 0, 0, 0);
          if ($urandom_range(0, 15) == 0) r.last = ~r.last;
          send_element(r);
          n_items++;
        end
      end
      drain_sets();
      phase++;
    end
    stim_done = 1'b1;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end else begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) stall = 0;
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    set_result_t want;
    set_result_t typed;
    logic        has_typed;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_sets.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat stat=%h sat=%b",
                                       out_if.statistic, out_if.saturated);
      end else begin
        want = expected_sets.pop_front();
        typed = typed_sets.pop_front();
        has_typed = typed_valid.pop_front();
        if (has_typed && typed != want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("table row disagrees with predictor: %h/%b vs %h/%b",
                                         typed.statistic, typed.saturated,
                                         want.statistic, want.saturated);
        end
        if (out_if.statistic !== want.statistic || out_if.saturated !== want.saturated) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: exp %h/%b got %h/%b",
                                         want.statistic, want.saturated,
                                         out_if.statistic, out_if.saturated);
        end
      end
    end
  end

  initial begin
    failed = 1'b0;
    mismatches = 0;
    wait (stim_done);
    repeat (300) @(posedge clk_i);
    if (expected_sets.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/mts_pkg.sv
sv/mts_if.sv
sv/mts_front.sv
sv/mts_back.sv
sv/max_type_standardized_statistic.sv
test/tb.sv
